>>> sv/sfs_pkg.sv
// ----------------------------------------------------------------------------
// sfs_pkg
// Shared types, codes and the result sequence table of the SPI flash sector
// sequencer.
// ----------------------------------------------------------------------------
package sfs_pkg;

  // Geometry of the storage window
  localparam int unsigned SECTOR_BYTES      = 4096;
  localparam int unsigned IDLE_READS_NEEDED = 3;
  localparam logic [23:0] REGION_BASE_RST   = 24'h780000;

  // Default depth of the job queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;

  // SPI command bytes
  localparam logic [7:0] CMD_WREN  = 8'h06;
  localparam logic [7:0] CMD_WRDI  = 8'h04;
  localparam logic [7:0] CMD_RDSR  = 8'h05;
  localparam logic [7:0] CMD_READ  = 8'h03;
  localparam logic [7:0] CMD_PROG  = 8'h02;
  localparam logic [7:0] CMD_ERASE = 8'h20;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_PROG  = 2'd1,
    OP_ERASE = 2'd2,
    OP_RX    = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ACT_SELECT  = 3'd0,
    ACT_SEND    = 3'd1,
    ACT_CLOCK   = 3'd2,
    ACT_RELEASE = 3'd3,
    ACT_DONE    = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_READ = 2'd1,
    PH_POLL = 2'd2
  } phase_e;

  // Work handed from the front to the back
  typedef enum logic [2:0] {
    JOB_RANGE = 3'd0,  // rejected request: done with range flag
    JOB_READ  = 3'd1,  // read command up to the data clock-in
    JOB_PROG  = 3'd2,  // write enable, program, start of status poll
    JOB_ERASE = 3'd3,  // write enable, sector erase, start of status poll
    JOB_RDONE = 3'd4,  // release and done with the read byte
    JOB_PDONE = 3'd5,  // poll finished: write disable and done
    JOB_CLOCK = 3'd6   // clock in one more status byte
  } job_kind_e;

  typedef struct packed {
    logic [1:0]  operation;
    logic [6:0]  sector;
    logic [15:0] offset;
    logic [7:0]  data;
    logic [7:0]  rx_byte;
  } sfs_in_t;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] tx_byte;
    logic [7:0] read_data;
    logic       range_error;
    logic       last;
  } sfs_out_t;

  typedef struct packed {
    job_kind_e   kind;
    logic [23:0] addr;
    logic [7:0]  data;
  } job_t;

  function automatic sfs_out_t mk_res(action_e act, logic [7:0] tx, logic [7:0] rd,
                                      logic rerr, logic lst);
    sfs_out_t r;
    r.action      = act;
    r.tx_byte     = tx;
    r.read_data   = rd;
    r.range_error = rerr;
    r.last        = lst;
    return r;
  endfunction

  function automatic sfs_out_t act_res(action_e act, logic lst);
    return mk_res(act, 8'h00, 8'h00, 1'b0, lst);
  endfunction

  function automatic sfs_out_t send_res(logic [7:0] tx);
    return mk_res(ACT_SEND, tx, 8'h00, 1'b0, 1'b0);
  endfunction

  // Result number 'step' of a job; the final one carries last
  function automatic sfs_out_t job_result(job_t job, logic [3:0] step);
    sfs_out_t r;
    r = act_res(ACT_DONE, 1'b1);
    unique case (job.kind)
      JOB_RANGE: begin
        r = mk_res(ACT_DONE, 8'h00, 8'h00, 1'b1, 1'b1);
      end
      JOB_READ: begin
        case (step)
          4'd0:    r = act_res(ACT_SELECT, 1'b0);
          4'd1:    r = send_res(CMD_READ);
          4'd2:    r = send_res(job.addr[23:16]);
          4'd3:    r = send_res(job.addr[15:8]);
          4'd4:    r = send_res(job.addr[7:0]);
          default: r = act_res(ACT_CLOCK, 1'b1);
        endcase
      end
      JOB_PROG: begin
        case (step)
          4'd0:    r = act_res(ACT_SELECT, 1'b0);
          4'd1:    r = send_res(CMD_WREN);
          4'd2:    r = act_res(ACT_RELEASE, 1'b0);
          4'd3:    r = act_res(ACT_SELECT, 1'b0);
          4'd4:    r = send_res(CMD_PROG);
          4'd5:    r = send_res(job.addr[23:16]);
          4'd6:    r = send_res(job.addr[15:8]);
          4'd7:    r = send_res(job.addr[7:0]);
          4'd8:    r = send_res(job.data);
          4'd9:    r = act_res(ACT_RELEASE, 1'b0);
          4'd10:   r = act_res(ACT_SELECT, 1'b0);
          4'd11:   r = send_res(CMD_RDSR);
          default: r = act_res(ACT_CLOCK, 1'b1);
        endcase
      end
      JOB_ERASE: begin
        case (step)
          4'd0:    r = act_res(ACT_SELECT, 1'b0);
          4'd1:    r = send_res(CMD_WREN);
          4'd2:    r = act_res(ACT_RELEASE, 1'b0);
          4'd3:    r = act_res(ACT_SELECT, 1'b0);
          4'd4:    r = send_res(CMD_ERASE);
          4'd5:    r = send_res(job.addr[23:16]);
          4'd6:    r = send_res(job.addr[15:8]);
          4'd7:    r = send_res(job.addr[7:0]);
          4'd8:    r = act_res(ACT_RELEASE, 1'b0);
          4'd9:    r = act_res(ACT_SELECT, 1'b0);
          4'd10:   r = send_res(CMD_RDSR);
          default: r = act_res(ACT_CLOCK, 1'b1);
        endcase
      end
      JOB_RDONE: begin
        case (step)
          4'd0:    r = act_res(ACT_RELEASE, 1'b0);
          default: r = mk_res(ACT_DONE, 8'h00, job.data, 1'b0, 1'b1);
        endcase
      end
      JOB_PDONE: begin
        case (step)
          4'd0:    r = act_res(ACT_RELEASE, 1'b0);
          4'd1:    r = act_res(ACT_SELECT, 1'b0);
          4'd2:    r = send_res(CMD_WRDI);
          4'd3:    r = act_res(ACT_RELEASE, 1'b0);
          default: r = act_res(ACT_DONE, 1'b1);
        endcase
      end
      JOB_CLOCK: begin
        r = act_res(ACT_CLOCK, 1'b1);
      end
      default: begin
        r = act_res(ACT_DONE, 1'b1);
      end
    endcase
    return r;
  endfunction

endpackage

>>> sv/spi_flash_sector_eeprom_sequencer.sv
// A beat's job waits in the job queue; its results are offered from the result register.
// Throughput: one input beat per cycle while the job queue has room; the back end
//   emits one result per cycle while not stalled, holding a job until its last result.
// Queue depth QUEUE_DEPTH sets how many jobs may wait ahead of the result sequencer.
// Reset (rst_ni low, async): phase idle, poll streak zero, queue and output empty,
//   region_base back to 0x780000.
// ----------------------------------------------------------------------------
// spi_flash_sector_eeprom_sequencer
// SPI NOR flash command sequencer: front classifies beats, back emits actions.
// ----------------------------------------------------------------------------
module spi_flash_sector_eeprom_sequencer #(
  parameter int unsigned QUEUE_DEPTH = sfs_pkg::QUEUE_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  sfs_pkg::sfs_in_t  in_item_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output sfs_pkg::sfs_out_t out_item_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [23:0]       cfg_data_i
);

  logic          q_full;
  logic          q_push;
  sfs_pkg::job_t q_job;
  logic          q_pop;
  logic          q_head_valid;
  sfs_pkg::job_t q_head_job;

  sfs_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_job_o     (q_job)
  );

  sfs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (q_push),
    .push_job_i   (q_job),
    .full_o       (q_full),
    .pop_i        (q_pop),
    .head_valid_o (q_head_valid),
    .head_job_o   (q_head_job)
  );

  sfs_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (q_head_valid),
    .head_job_i   (q_head_job),
    .pop_o        (q_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_item_o   (out_item_o)
  );

endmodule

>>> sv/sfs_front.sv
// ----------------------------------------------------------------------------
// sfs_front
// Accepts request and flash-byte beats, tracks the protocol phase and the
// status poll streak, and turns each beat into at most one job.
// ----------------------------------------------------------------------------
module sfs_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  sfs_pkg::sfs_in_t in_item_i,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [23:0]     cfg_data_i,
  input  logic            q_full_i,
  output logic            q_push_o,
  output sfs_pkg::job_t   q_job_o
);

  sfs_pkg::phase_e phase_q, phase_d;
  logic [1:0]      streak_q, streak_d;
  logic [23:0]     region_base_q;

  logic            accept;
  sfs_pkg::op_e    op;
  logic            in_range;
  logic            req_ok;
  logic [1:0]      streak_inc;
  logic            poll_done;
  logic [23:0]     sec_term;
  logic [23:0]     sbase;
  logic [23:0]     addr;

  assign in_stall_o  = q_full_i;
  assign accept      = in_valid_i & ~q_full_i;
  assign cfg_ready_o = 1'b1;

  // Decode and address arithmetic
  assign op         = sfs_pkg::op_e'(in_item_i.operation);
  assign in_range   = {16'b0, in_item_i.offset} < 32'(sfs_pkg::SECTOR_BYTES);
  assign req_ok     = (op == sfs_pkg::OP_ERASE) | in_range;
  assign sec_term   = 24'(32'(in_item_i.sector) * 32'(sfs_pkg::SECTOR_BYTES));
  assign sbase      = region_base_q + sec_term;
  assign addr       = sbase + {8'b0, in_item_i.offset};
  assign streak_inc = (streak_q < 2'd3) ? streak_q + 2'd1 : streak_q;
  assign poll_done  = ~in_item_i.rx_byte[0] &
                      (streak_inc >= 2'(sfs_pkg::IDLE_READS_NEEDED));

  // Next phase and streak
  always_comb begin
    phase_d  = phase_q;
    streak_d = streak_q;
    if (accept) begin
      unique case (phase_q)
        sfs_pkg::PH_IDLE: begin
          if (op != sfs_pkg::OP_RX && req_ok) begin
            phase_d  = (op == sfs_pkg::OP_READ) ? sfs_pkg::PH_READ : sfs_pkg::PH_POLL;
            streak_d = 2'd0;
          end
        end
        sfs_pkg::PH_READ: begin
          if (op == sfs_pkg::OP_RX) begin
            phase_d = sfs_pkg::PH_IDLE;
          end
        end
        sfs_pkg::PH_POLL: begin
          if (op == sfs_pkg::OP_RX) begin
            if (in_item_i.rx_byte[0]) begin
              streak_d = 2'd0;
            end else if (poll_done) begin
              phase_d  = sfs_pkg::PH_IDLE;
              streak_d = 2'd0;
            end else begin
              streak_d = streak_inc;
            end
          end
        end
        default: begin
          phase_d  = sfs_pkg::PH_IDLE;
          streak_d = 2'd0;
        end
      endcase
    end
  end

  // Job classification
  always_comb begin
    q_push_o     = 1'b0;
    q_job_o.kind = sfs_pkg::JOB_CLOCK;
    q_job_o.addr = addr;
    q_job_o.data = in_item_i.data;
    unique case (phase_q)
      sfs_pkg::PH_IDLE: begin
        if (op != sfs_pkg::OP_RX) begin
          q_push_o = accept;
          if (!req_ok) begin
            q_job_o.kind = sfs_pkg::JOB_RANGE;
          end else begin
            unique case (op)
              sfs_pkg::OP_READ:  q_job_o.kind = sfs_pkg::JOB_READ;
              sfs_pkg::OP_PROG:  q_job_o.kind = sfs_pkg::JOB_PROG;
              default: begin
                q_job_o.kind = sfs_pkg::JOB_ERASE;
                q_job_o.addr = sbase;
              end
            endcase
          end
        end
      end
      sfs_pkg::PH_READ: begin
        if (op == sfs_pkg::OP_RX) begin
          q_push_o     = accept;
          q_job_o.kind = sfs_pkg::JOB_RDONE;
          q_job_o.data = in_item_i.rx_byte;
        end
      end
      sfs_pkg::PH_POLL: begin
        if (op == sfs_pkg::OP_RX) begin
          q_push_o     = accept;
          q_job_o.kind = poll_done ? sfs_pkg::JOB_PDONE : sfs_pkg::JOB_CLOCK;
        end
      end
      default: begin
        q_push_o = 1'b0;
      end
    endcase
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= sfs_pkg::PH_IDLE;
      streak_q      <= 2'd0;
      region_base_q <= sfs_pkg::REGION_BASE_RST;
    end else begin
      phase_q  <= phase_d;
      streak_q <= streak_d;
      if (cfg_valid_i && cfg_ready_o) begin
        region_base_q <= cfg_data_i;
      end
    end
  end

`ifndef SYNTHESIS
  // streak only counts while polling
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q != sfs_pkg::PH_POLL |-> streak_q == 2'd0)
    else $error("poll streak nonzero outside polling");
`endif

endmodule

>>> sv/sfs_queue.sv
// ----------------------------------------------------------------------------
// sfs_queue
// Small job FIFO that decouples classification from result sequencing.
// ----------------------------------------------------------------------------
module sfs_queue #(
  parameter int unsigned DEPTH = sfs_pkg::QUEUE_DEPTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  sfs_pkg::job_t push_job_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          head_valid_o,
  output sfs_pkg::job_t head_job_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  sfs_pkg::job_t mem_q [DEPTH];
  logic [PW-1:0] wr_q, rd_q;
  logic [CW-1:0] count_q;

  assign full_o       = count_q == CW'(DEPTH);
  assign head_valid_o = count_q != '0;
  assign head_job_o   = mem_q[rd_q];

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_job_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni) push_i |-> !full_o)
    else $error("job queue overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_i |-> head_valid_o)
    else $error("job queue underflow");
`endif

endmodule

>>> sv/sfs_back.sv
// ----------------------------------------------------------------------------
// sfs_back
// Walks the job at the queue head one result per cycle, while the output is not
// stalled, into the output register, popping the job with its final result.
// ----------------------------------------------------------------------------
module sfs_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              head_valid_i,
  input  sfs_pkg::job_t     head_job_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output sfs_pkg::sfs_out_t out_item_o
);

  logic [3:0]        step_q;
  logic              out_valid_q;
  sfs_pkg::sfs_out_t res_q;
  sfs_pkg::sfs_out_t res;
  logic              load;

  assign res   = sfs_pkg::job_result(head_job_i, step_q);
  assign load  = head_valid_i & (~out_valid_q | ~out_stall_i);
  assign pop_o = load & res.last;

  assign out_valid_o = out_valid_q;
  assign out_item_o  = res_q;

  // Result register
  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= res;
    end
  end

  // Step counter and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= 4'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        step_q      <= res.last ? 4'd0 : step_q + 4'd1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  // longest job is thirteen results
  assert property (@(posedge clk_i) disable iff (!rst_ni) step_q <= 4'd12)
    else $error("step counter ran past the longest job");
  // a job in progress stays at the queue head
  assert property (@(posedge clk_i) disable iff (!rst_ni) step_q != 4'd0 |-> head_valid_i)
    else $error("job left the queue mid-sequence");
`endif

endmodule
